>>> rtl/boa_pkg.sv
// shared types, field widths and codes of the bitmap object allocator
package boa_pkg;

  // field widths
  localparam int TOT_W     = 13;  // object_total register
  localparam int SIZE_W    = 17;  // object_size register, request_length
  localparam int HINT_W    = 7;
  localparam int IDX_W     = 12;
  localparam int NEXT_W    = 8;
  localparam int STAT_W    = 3;
  localparam int CNT_W     = 13;  // free counter, holds any total minus two
  localparam int CFG_IDX_W = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_TOTAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE  = 2'd1;

  // reset values of the configuration registers
  localparam logic [TOT_W-1:0]  OBJECT_TOTAL_RST = 13'd4096;
  localparam logic [SIZE_W-1:0] OBJECT_SIZE_RST  = 17'd2048;

  // request kinds
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_TOO_LARGE    = 3'd1,
    ST_NO_MEM       = 3'd2,
    ST_NOT_FOUND    = 3'd3,
    ST_BAD_INDEX    = 3'd4,
    ST_ALREADY_FREE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_BUILD,
    S_IDLE,
    S_DECIDE,
    S_SCAN,
    S_FREE,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic build_step;
    logic decide;
    logic scan;
    logic free_upd;
    logic res_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rebuild;
    logic build_last;
    logic is_free;
    logic dec_early;
    logic scan_stop;
    logic res_free;
  } sts_t;

endpackage

>>> rtl/bitmap_object_allocator_core.sv
// top level of the bitmap object allocator
//
//   channel   dir  handshake               payload
//   s_*       in   s_tvalid / s_tready     request: kind in tuser, length, hint, index
//   m_*       out  m_tvalid / m_tready     result: status in tuser, index, hint, count
//   cfg_*     in   cfg_valid / cfg_ready   register index and write data
//
// an allocate reads the hint word and, when it holds no free object, scans
// the following bitmap words, one memory read per cycle; rejected requests
// skip the read, and frees read and update the word of their index
// after reset and after every object_total write the bitmap is rebuilt by a
// sweep over all MAP_WORDS words, one word a cycle, while s_tready stays low
// a result waits in the output register while the next item is taken in;
// the block stalls only at completion while that register is still full
// cfg_ready is always high
module bitmap_object_allocator_core import boa_pkg::*; #(
  parameter int MAX_OBJECTS = 4096,
  parameter int MAP_WORDS   = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  // request items
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // request_length[16:0], hint_word[23:17],
                                           // free_index[35:24], zero fill
  input  logic                  s_tuser,   // command
  // result items
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // obj_index[11:0], next_hint[19:12],
                                           // free_count[31:20]
  output logic [STAT_W-1:0]     m_tuser,   // status
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data
);

  cmd_t cmd;
  sts_t sts;

  logic [IDX_W-1:0]  out_obj;
  logic [NEXT_W-1:0] out_next;
  logic [IDX_W-1:0]  out_count;

  // configuration is never held off
  assign cfg_ready = 1'b1;

  boa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  boa_datapath #(
    .MAX_OBJECTS (MAX_OBJECTS),
    .MAP_WORDS   (MAP_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_cmd     (s_tuser),
    .in_len     (s_tdata[16:0]),
    .in_hint    (s_tdata[23:17]),
    .in_fidx    (s_tdata[35:24]),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (m_tuser),
    .out_obj    (out_obj),
    .out_next   (out_next),
    .out_count  (out_count),
    .cmd        (cmd),
    .sts        (sts)
  );

  // pack result fields, lowest field first
  assign m_tdata = {out_count, out_next, out_obj};

endmodule

>>> rtl/boa_ctrl.sv
// sequencer of the bitmap object allocator
module boa_ctrl import boa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BUILD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_BUILD: begin
        cmd.build_step = 1'b1;
        if (sts.build_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = !sts.rebuild;
        if (in_valid && !sts.rebuild) begin
          cmd.load_item = 1'b1;
          state_next    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.dec_early) begin
          state_next = S_DONE;
        end else if (sts.is_free) begin
          state_next = S_FREE;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_stop) state_next = S_DONE;
      end
      S_FREE: begin
        cmd.free_upd = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (sts.res_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_BUILD;
    endcase
    // a new pool total restarts the rebuild sweep
    if (sts.rebuild) state_next = S_BUILD;
  end

endmodule

>>> rtl/boa_datapath.sv
// bitmap memory, counters, configuration and result registers of the allocator
module boa_datapath import boa_pkg::*; #(
  parameter int MAX_OBJECTS = 4096,
  parameter int MAP_WORDS   = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [SIZE_W-1:0]     cfg_data,
  input  logic                  in_cmd,
  input  logic [SIZE_W-1:0]     in_len,
  input  logic [HINT_W-1:0]     in_hint,
  input  logic [IDX_W-1:0]      in_fidx,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [STAT_W-1:0]     out_status,
  output logic [IDX_W-1:0]      out_obj,
  output logic [NEXT_W-1:0]     out_next,
  output logic [IDX_W-1:0]      out_count,
  input  cmd_t                  cmd,
  output sts_t                  sts
);

  localparam int WORD_W = $clog2(MAP_WORDS);
  localparam int PTR_W  = ((WORD_W > HINT_W) ? WORD_W : HINT_W) + 1;
  localparam int LO_W   = WORD_W + 5;
  localparam int CW     = ((LO_W > TOT_W) ? LO_W : TOT_W) + 1;
  localparam logic [31:0] CAP = (MAX_OBJECTS < MAP_WORDS * 32) ? MAX_OBJECTS : MAP_WORDS * 32;
  localparam logic [PTR_W-1:0]  MAP_END   = PTR_W'(MAP_WORDS);
  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(MAP_WORDS - 1);

  // configuration
  logic [TOT_W-1:0]  object_total;
  logic [SIZE_W-1:0] object_size;
  logic [TOT_W-1:0]  eff_total;

  // latched item
  logic              it_cmd;
  logic [SIZE_W-1:0] it_len;
  logic [HINT_W-1:0] it_hint;
  logic [IDX_W-1:0]  it_fidx;

  logic [WORD_W-1:0] sweep_ptr;
  logic [PTR_W-1:0]  scan_word;
  logic [CNT_W-1:0]  free_counter;
  status_t           pend_status;
  logic [IDX_W-1:0]  pend_obj;
  logic [PTR_W-1:0]  pend_next;

  logic              res_valid;
  logic [STAT_W-1:0] res_status;
  logic [IDX_W-1:0]  res_obj;
  logic [NEXT_W-1:0] res_next;
  logic [IDX_W-1:0]  res_count;

  // bitmap memory, one read and one write port
  logic [31:0]       free_map [MAP_WORDS];
  logic [31:0]       rdata;
  logic              mem_we, mem_re;
  logic [WORD_W-1:0] mem_waddr, mem_raddr;
  logic [31:0]       mem_wdata;

  // build pattern
  logic [CW-1:0]     lo_c, tot_c, diff;
  logic [31:0]       pattern;
  logic [CNT_W-1:0]  build_count;

  // decision and scan
  logic              is_free, too_large, no_mem, hint_out, bad_idx, dec_early;
  logic [PTR_W-1:0]  hint_ptr, scan_next;
  logic [WORD_W-1:0] fidx_word;
  logic [31:0]       fmask, iso;
  logic [4:0]        bitpos;
  logic              hit, scan_end, scan_stop, bit_set;
  logic              rebuild;

  assign eff_total = (32'(object_total) > CAP) ? CAP[TOT_W-1:0] : object_total;
  assign rebuild   = cfg_valid && (cfg_index == REG_OBJECT_TOTAL);

  always_comb begin
    lo_c  = CW'({sweep_ptr, 5'b0});
    tot_c = CW'(eff_total);
    diff  = tot_c - lo_c;
    if (lo_c >= tot_c) begin
      pattern = '0;
    end else if (diff >= CW'(32)) begin
      pattern = '1;
    end else begin
      pattern = (32'd1 << diff[4:0]) - 32'd1;
    end
    // objects 0 and 1 stay reserved
    if (sweep_ptr == '0) pattern = pattern & ~32'd3;
  end

  assign build_count = (eff_total > TOT_W'(2)) ? CNT_W'(eff_total - TOT_W'(2)) : '0;

  assign is_free   = (it_cmd == CMD_FREE);
  assign too_large = it_len > object_size;
  assign no_mem    = (free_counter == '0);
  assign hint_ptr  = PTR_W'(it_hint);
  assign hint_out  = hint_ptr >= MAP_END;
  assign bad_idx   = (it_fidx < IDX_W'(2)) || (TOT_W'(it_fidx) >= eff_total);
  assign dec_early = is_free ? bad_idx : (too_large || no_mem || hint_out);
  assign fidx_word = WORD_W'(it_fidx[IDX_W-1:5]);
  assign fmask     = 32'd1 << it_fidx[4:0];
  assign bit_set   = |(rdata & fmask);

  // lowest set bit of the fetched word
  assign iso = rdata & (~rdata + 32'd1);
  always_comb begin
    bitpos = '0;
    for (int k = 0; k < 5; k++) begin
      for (int b = 0; b < 32; b++) begin
        if (((b >> k) & 1) == 1) bitpos[k] = bitpos[k] | iso[b];
      end
    end
  end

  assign hit       = (rdata != '0);
  assign scan_next = scan_word + PTR_W'(1);
  assign scan_end  = (scan_next == MAP_END);
  assign scan_stop = hit || scan_end;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_ptr;
    mem_wdata = pattern;
    mem_re    = 1'b0;
    mem_raddr = hint_ptr[WORD_W-1:0];
    if (cmd.build_step) begin
      mem_we = 1'b1;
    end else if (cmd.scan && hit) begin
      mem_we    = 1'b1;
      mem_waddr = scan_word[WORD_W-1:0];
      mem_wdata = rdata & ~iso;
    end else if (cmd.free_upd && !bit_set) begin
      mem_we    = 1'b1;
      mem_waddr = fidx_word;
      mem_wdata = rdata | fmask;
    end
    if (cmd.decide && !dec_early) begin
      mem_re    = 1'b1;
      mem_raddr = is_free ? fidx_word : hint_ptr[WORD_W-1:0];
    end else if (cmd.scan && !scan_stop) begin
      mem_re    = 1'b1;
      mem_raddr = scan_next[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) free_map[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= free_map[mem_raddr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      object_total <= OBJECT_TOTAL_RST;
      object_size  <= OBJECT_SIZE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_OBJECT_TOTAL: object_total <= cfg_data[TOT_W-1:0];
        REG_OBJECT_SIZE:  object_size  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_ptr <= '0;
    end else if (rebuild) begin
      sweep_ptr <= '0;
    end else if (cmd.build_step) begin
      sweep_ptr <= sweep_ptr + WORD_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_counter <= '0;
    end else if (cmd.build_step) begin
      free_counter <= build_count;
    end else if (cmd.scan && hit) begin
      free_counter <= free_counter - CNT_W'(1);
    end else if (cmd.free_upd && !bit_set) begin
      free_counter <= free_counter + CNT_W'(1);
    end
  end

  // item and pending result
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      it_cmd  <= in_cmd;
      it_len  <= in_len;
      it_hint <= in_hint;
      it_fidx <= in_fidx;
    end
    if (cmd.decide) begin
      pend_obj    <= '0;
      pend_status <= ST_OK;
      pend_next   <= is_free ? '0 : hint_ptr;
      scan_word   <= hint_ptr;
      if (is_free) begin
        if (bad_idx) pend_status <= ST_BAD_INDEX;
      end else if (too_large) begin
        pend_status <= ST_TOO_LARGE;
      end else if (no_mem) begin
        pend_status <= ST_NO_MEM;
      end else if (hint_out) begin
        pend_status <= ST_NOT_FOUND;
        pend_next   <= MAP_END;
      end
    end
    if (cmd.scan) begin
      if (hit) begin
        pend_obj  <= IDX_W'({scan_word[WORD_W-1:0], bitpos});
        pend_next <= scan_word;
      end else if (scan_end) begin
        pend_status <= ST_NOT_FOUND;
        pend_next   <= MAP_END;
      end else begin
        scan_word <= scan_next;
      end
    end
    if (cmd.free_upd && bit_set) pend_status <= ST_ALREADY_FREE;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_status <= pend_status;
      res_obj    <= pend_obj;
      res_next   <= NEXT_W'(pend_next);
      res_count  <= IDX_W'(free_counter);
    end
  end

  assign out_valid  = res_valid;
  assign out_status = res_status;
  assign out_obj    = res_obj;
  assign out_next   = res_next;
  assign out_count  = res_count;

  always_comb begin
    sts.rebuild    = rebuild;
    sts.build_last = (sweep_ptr == LAST_WORD);
    sts.is_free    = is_free;
    sts.dec_early  = dec_early;
    sts.scan_stop  = scan_stop;
    sts.res_free   = !res_valid || out_ready;
  end

endmodule

>>> rtl/boa_checker.sv
// port level checks of the bitmap object allocator, bound to the top level
module boa_checker import boa_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [STAT_W-1:0]     m_tuser
);

  // items taken in whose result has not been taken yet
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 2'(s_tvalid && s_tready) - 2'(m_tvalid && m_tready);
    end
  end

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_no_extra_result: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 2'd0)
    else $error("result without a pending request");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many requests in flight");

  a_fail_index_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_OK |-> m_tdata[11:0] == '0)
    else $error("failed request returned an object index");

  a_free_hint_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_BAD_INDEX || m_tuser == ST_ALREADY_FREE)
      |-> m_tdata[19:12] == '0)
    else $error("free result carries a hint");

endmodule

bind bitmap_object_allocator_core boa_checker u_boa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> test/bitmap_object_allocator_core_tb.sv
`timescale 1ns / 100ps
// self-checking testbench of the bitmap object allocator: directed and random requests

module bitmap_object_allocator_core_tb;
  import boa_pkg::*;

  localparam int MAX_OBJECTS = 4096;
  localparam int MAP_WORDS   = 128;
  localparam int LONG_HOLD   = 400;  // receiver hold-off while the sender keeps offering items

  // one expected result item
  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] obj;
    logic [7:0]       next_hint;
    logic [11:0]      count;
  } alloc_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // request_length, hint_word, free_index, zero fill
  logic                  s_tuser = CMD_ALLOC;  // command
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // obj_index, next_hint, free_count
  logic [STAT_W-1:0]     m_tuser;        // status
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_OBJECT_TOTAL;
  logic [SIZE_W-1:0]     cfg_data = '0;

  bitmap_object_allocator_core #(
    .MAX_OBJECTS(MAX_OBJECTS),
    .MAP_WORDS  (MAP_WORDS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted pool state and register copies
  logic [31:0]   pool_map [MAP_WORDS];
  int unsigned   pool_free;
  int unsigned   reg_total;
  int unsigned   reg_size;
  alloc_result_t pending_results[$];  // results owed by the block, oldest first
  int unsigned   live_objs[$];        // objects currently handed out
  int unsigned   mismatches = 0;

  // idling controls
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int unsigned hold_req = 0;

  // total clamped to the pool capacity
  function automatic int unsigned usable_total();
    int unsigned t;
    t = reg_total;
    if (t > MAX_OBJECTS) t = MAX_OBJECTS;
    if (t > MAP_WORDS * 32) t = MAP_WORDS * 32;
    return t;
  endfunction

  // every object below the total is free, except the two reserved ones
  function automatic void rebuild_pool();
    int unsigned t;
    int unsigned lo;
    t = usable_total();
    for (int w = 0; w < MAP_WORDS; w++) begin
      lo = w * 32;
      if (lo >= t) pool_map[w] = '0;
      else if (t - lo >= 32) pool_map[w] = '1;
      else pool_map[w] = (32'd1 << (t - lo)) - 32'd1;
    end
    pool_map[0][1:0] = 2'b00;
    pool_free = (t > 2) ? t - 2 : 0;
  endfunction

  // applies one request to the predicted pool and returns what the block must report
  function automatic alloc_result_t apply_request(logic cmd, int unsigned len,
                                                  int unsigned hint, int unsigned fidx);
    alloc_result_t res;
    int unsigned   w;
    int unsigned   b;
    bit            found;
    res.status    = ST_OK;
    res.obj       = '0;
    res.next_hint = '0;
    found         = 1'b0;
    if (cmd == CMD_ALLOC) begin
      if (len > reg_size) begin
        res.status    = ST_TOO_LARGE;
        res.next_hint = hint[7:0];
      end else if (pool_free == 0) begin
        res.status    = ST_NO_MEM;
        res.next_hint = hint[7:0];
      end else begin
        // scan upward for the first word with a free bit, take its lowest one
        for (w = hint; w < MAP_WORDS && !found; w++) begin
          if (pool_map[w] != 0) begin
            for (b = 0; pool_map[w][b] == 1'b0; b++) ;
            pool_map[w][b] = 1'b0;
            pool_free--;
            res.obj       = IDX_W'(w * 32 + b);
            res.next_hint = w[7:0];
            found         = 1'b1;
          end
        end
        if (!found) begin
          res.status    = ST_NOT_FOUND;
          res.next_hint = 8'(MAP_WORDS);
        end
      end
    end else begin
      if (fidx < 2 || fidx >= usable_total()) begin
        res.status = ST_BAD_INDEX;
      end else if (pool_map[fidx >> 5][fidx & 31]) begin
        res.status = ST_ALREADY_FREE;
      end else begin
        pool_map[fidx >> 5][fidx & 31] = 1'b1;
        pool_free++;
      end
    end
    res.count = pool_free[11:0];
    return res;
  endfunction

  // drive one request item, wait for it to be taken, then record what it must produce
  task automatic send_request(logic cmd, int unsigned len, int unsigned hint,
                              int unsigned fidx);
    int unsigned   gap;
    alloc_result_t res;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0, fidx[IDX_W-1:0], hint[HINT_W-1:0], len[SIZE_W-1:0]};
    do @(posedge clk); while (!s_tready);
    res = apply_request(cmd, len, hint, fidx);
    pending_results.push_back(res);
    // keep the list of handed-out objects in step with the pool
    if (res.status == ST_OK) begin
      if (cmd == CMD_ALLOC) begin
        live_objs.push_back(res.obj);
      end else begin
        for (int k = 0; k < live_objs.size(); k++) begin
          if (live_objs[k] == fidx) begin
            live_objs.delete(k);
            break;
          end
        end
      end
    end
  endtask

  // stop offering items and wait until every owed result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // register write, only with the block idle
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    wait_drained();
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[SIZE_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_OBJECT_TOTAL) begin
      reg_total = value & 32'h1FFF;
      rebuild_pool();
      live_objs.delete();
    end else if (idx == REG_OBJECT_SIZE) begin
      reg_size = value & 32'h1FFFF;
    end
    @(posedge clk);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result side: random stalls, optional long hold-off, compare against the oldest prediction
  int unsigned rx_wait = 0;
  int unsigned hold_seen = 0;
  always @(posedge clk) begin
    alloc_result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d data %h",
                   $time, m_tuser, m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", want.status, m_tuser);
          check_field("obj_index", want.obj, m_tdata[11:0]);
          check_field("next_hint", want.next_hint, m_tdata[19:12]);
          check_field("free_count", want.count, m_tdata[31:20]);
        end
        rx_wait = rx_idle_on ? $urandom_range(0, 9) : 0;
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        rx_wait   = LONG_HOLD;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // fresh pool: lowest free object, last word, a word in the middle
  task automatic test_reset_pool();
    send_request(CMD_ALLOC, 0, 0, 0);
    send_request(CMD_ALLOC, 2048, 127, 4095);
    send_request(CMD_ALLOC, 100, 5, 0);
  endtask

  // lengths just over and equal to the object size, and a length of 65536
  task automatic test_length_limits();
    send_request(CMD_ALLOC, 2049, 3, 0);
    send_request(CMD_ALLOC, 65536, 127, 0);
    write_register(REG_OBJECT_SIZE, 64);
    send_request(CMD_ALLOC, 65, 0, 0);
    send_request(CMD_ALLOC, 64, 0, 0);
    write_register(REG_OBJECT_SIZE, 65536);
    send_request(CMD_ALLOC, 65536, 1, 0);
  endtask

  // reserved indexes, release of a taken object, double release
  task automatic test_free_checks();
    send_request(CMD_FREE, 0, 0, 0);
    send_request(CMD_FREE, 65536, 127, 1);
    send_request(CMD_FREE, 0, 0, 4064);
    send_request(CMD_FREE, 0, 0, 4064);
    send_request(CMD_FREE, 0, 0, 4095);
  endtask

  // four-object pool: exhaustion, index past the total, scan from an empty word
  task automatic test_small_pool();
    write_register(REG_OBJECT_TOTAL, 4);
    send_request(CMD_ALLOC, 10, 0, 0);
    send_request(CMD_ALLOC, 10, 0, 0);
    send_request(CMD_ALLOC, 10, 0, 0);
    send_request(CMD_FREE, 0, 0, 4);
    send_request(CMD_FREE, 0, 0, 3);
    send_request(CMD_ALLOC, 10, 1, 0);
    send_request(CMD_ALLOC, 10, 0, 0);
  endtask

  // total below two leaves nothing; total above capacity is clamped
  task automatic test_odd_totals();
    write_register(REG_OBJECT_TOTAL, 1);
    send_request(CMD_ALLOC, 0, 0, 0);
    send_request(CMD_FREE, 0, 0, 1);
    write_register(REG_OBJECT_TOTAL, 8191);
    send_request(CMD_ALLOC, 0, 127, 0);
  endtask

  // receiver holds off for a long stretch while requests keep coming, block must stall
  task automatic test_backpressure();
    write_register(REG_OBJECT_TOTAL, 200);
    tx_idle_on = 1'b0;
    rx_idle_on <= 1'b0;
    hold_req   <= hold_req + 1;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 2 && live_objs.size() > 0)
        send_request(CMD_FREE, 0, 0, live_objs[0]);
      else
        send_request(CMD_ALLOC, $urandom_range(0, 2048), $urandom_range(0, 6), 0);
    end
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on <= 1'b1;
  endtask

  // random allocate/free traffic over several pool settings
  task automatic test_random_mix();
    int unsigned phase_total[6] = '{4096, 80, 37, 300, 0, 8191};
    int unsigned phase_size[6]  = '{2048, 64, 0, 65536, 0, 0};
    int unsigned lim;
    int unsigned top;
    int unsigned hint;
    int unsigned r;
    int unsigned fidx;
    for (int p = 0; p < 6; p++) begin
      write_register(REG_OBJECT_TOTAL,
                     phase_total[p] != 0 ? phase_total[p] : $urandom_range(4, 4096));
      write_register(REG_OBJECT_SIZE,
                     phase_size[p] != 0 ? phase_size[p] : $urandom_range(64, 65536));
      tx_idle_on = (p % 3 != 2);
      rx_idle_on <= (p % 3 != 1) && (p != 5);
      for (int i = 0; i < 125; i++) begin
        lim  = usable_total();
        top  = (lim > 32) ? (lim - 1) / 32 : 0;
        // mostly hints inside the populated part of the map
        hint = ($urandom_range(0, 9) < 7) ? $urandom_range(0, top) : $urandom_range(0, 127);
        if ($urandom_range(0, 99) < 55) begin
          send_request(CMD_ALLOC,
                       ($urandom_range(0, 99) < 85) ? $urandom_range(0, reg_size)
                                                    : $urandom_range(0, 65536),
                       hint, $urandom_range(0, 4095));
        end else begin
          r = $urandom_range(0, 99);
          if (live_objs.size() > 0 && r < 75)
            fidx = live_objs[$urandom_range(0, live_objs.size() - 1)];
          else if (r < 90)
            fidx = $urandom_range(0, (lim > 0) ? lim - 1 : 0);
          else
            fidx = $urandom_range(0, 4095);
          send_request(CMD_FREE, $urandom_range(0, 65536), hint, fidx);
        end
      end
    end
  endtask

  initial begin
    reg_total = OBJECT_TOTAL_RST;
    reg_size  = OBJECT_SIZE_RST;
    rebuild_pool();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_pool();
    test_length_limits();
    test_free_checks();
    test_small_pool();
    test_odd_totals();
    test_backpressure();
    test_random_mix();
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
